// ----- hdl/sldc_pkg.sv -----
`default_nettype none

package sldc_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4088;

  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_GOOD     = 2'd1,
    EV_BAD      = 2'd2,
    EV_OVERSIZE = 2'd3
  } event_t;

  // One result of the parser, before it is packed onto the stream.
  typedef struct packed {
    event_t      ev;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [15:0] payload_index;
    logic [7:0]  data_byte;
    logic        error_seen;
  } res_t;

  // Layout of out_tdata; the last member sits in the lowest bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic        error_seen;
    logic [7:0]  data_byte;
    logic [15:0] payload_index;
    logic [15:0] payload_length;
    logic [7:0]  msg_id;
    logic [7:0]  msg_class;
  } out_data_t;

endpackage

`default_nettype wire

// ----- hdl/sldc_parser.sv -----
`default_nettype none

module sldc_parser (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [15:0]        cfg_data,
  input  wire                go,
  input  wire  [7:0]         byte_in,
  output logic               res_valid,
  output sldc_pkg::res_t     res
);

  typedef enum logic [3:0] {
    PH_HUNT0   = 4'd0,
    PH_HUNT1   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t     ph;
    logic [7:0] cls;
    logic [7:0] id;
    logic [7:0] sf;
    logic [7:0] ss;
  } hdr_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cls_r, cls_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  sf_r, sf_nxt;
  logic [7:0]  ss_r, ss_nxt;
  logic [7:0]  ck_r, ck_nxt;
  logic        err_r, err_nxt;
  logic [15:0] max_r;

  logic [7:0]  sf_add;
  logic [7:0]  ss_add;
  logic [15:0] len_new;
  logic [15:0] cnt_inc;
  hdr_t        rs0, rs1, rs2, rs3, rs4;

  // Header-side step of the parser, used when the held header bytes are
  // pushed through again after an oversize frame. Starting from hunting,
  // four bytes never get past the length phases.
  function automatic hdr_t hdr_step(hdr_t s, logic [7:0] c);
    hdr_t t;
    logic [7:0] f;
    t = s;
    f = s.sf + c;
    case (s.ph)
      PH_HUNT1: begin
        if (c == sldc_pkg::SYNC_SECOND) begin
          t.ph = PH_CLASS;
        end else if (c != sldc_pkg::SYNC_FIRST) begin
          t.ph = PH_HUNT0;
        end
      end
      PH_CLASS: begin
        t.cls = c;
        t.sf  = c;
        t.ss  = c;
        t.ph  = PH_ID;
      end
      PH_ID: begin
        t.id = c;
        t.sf = f;
        t.ss = s.ss + f;
        t.ph = PH_LEN_LO;
      end
      default: begin
        t.ph = (c == sldc_pkg::SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
      end
    endcase
    return t;
  endfunction

  assign sf_add  = sf_r + byte_in;
  assign ss_add  = ss_r + sf_add;
  assign len_new = {byte_in, len_r[7:0]};
  assign cnt_inc = cnt_r + 16'd1;

  assign rs0 = '{ph: PH_HUNT0, cls: cls_r, id: id_r, sf: sf_add, ss: ss_add};
  assign rs1 = hdr_step(rs0, cls_r);
  assign rs2 = hdr_step(rs1, id_r);
  assign rs3 = hdr_step(rs2, len_r[7:0]);
  assign rs4 = hdr_step(rs3, byte_in);

  always_comb begin
    phase_nxt = phase_r;
    cls_nxt   = cls_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sf_nxt    = sf_r;
    ss_nxt    = ss_r;
    ck_nxt    = ck_r;
    err_nxt   = err_r;
    res_valid = 1'b0;
    res.ev    = sldc_pkg::EV_DATA;
    res.payload_index = 16'd0;
    res.data_byte     = 8'd0;

    unique case (phase_r)
      PH_HUNT1: begin
        if (byte_in == sldc_pkg::SYNC_SECOND) begin
          phase_nxt = PH_CLASS;
        end else if (byte_in != sldc_pkg::SYNC_FIRST) begin
          phase_nxt = PH_HUNT0;
        end
      end
      PH_CLASS: begin
        cls_nxt   = byte_in;
        sf_nxt    = byte_in;
        ss_nxt    = byte_in;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = byte_in;
        sf_nxt    = sf_add;
        ss_nxt    = ss_add;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {8'd0, byte_in};
        sf_nxt    = sf_add;
        ss_nxt    = ss_add;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt = len_new;
        cnt_nxt = 16'd0;
        if (len_new > max_r) begin
          // Oversize: report, then rescan the held header bytes for a sync pair.
          res_valid = 1'b1;
          res.ev    = sldc_pkg::EV_OVERSIZE;
          phase_nxt = rs4.ph;
          cls_nxt   = rs4.cls;
          id_nxt    = rs4.id;
          sf_nxt    = rs4.sf;
          ss_nxt    = rs4.ss;
        end else begin
          sf_nxt    = sf_add;
          ss_nxt    = ss_add;
          phase_nxt = (len_new == 16'd0) ? PH_CK_A : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sf_nxt    = sf_add;
        ss_nxt    = ss_add;
        cnt_nxt   = cnt_inc;
        res_valid = 1'b1;
        res.payload_index = cnt_r;
        res.data_byte     = byte_in;
        if (cnt_inc >= len_r) begin
          phase_nxt = PH_CK_A;
        end
      end
      PH_CK_A: begin
        ck_nxt    = byte_in;
        phase_nxt = PH_CK_B;
      end
      PH_CK_B: begin
        phase_nxt = PH_HUNT0;
        res_valid = 1'b1;
        if (ck_r == sf_r && byte_in == ss_r) begin
          res.ev = sldc_pkg::EV_GOOD;
        end else begin
          res.ev  = sldc_pkg::EV_BAD;
          err_nxt = 1'b1;
        end
      end
      default: begin
        phase_nxt = (byte_in == sldc_pkg::SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
      end
    endcase

    res.msg_class      = cls_r;
    res.msg_id         = id_r;
    res.payload_length = len_nxt;
    res.error_seen     = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT0;
      cls_r   <= 8'd0;
      id_r    <= 8'd0;
      len_r   <= 16'd0;
      cnt_r   <= 16'd0;
      sf_r    <= 8'd0;
      ss_r    <= 8'd0;
      ck_r    <= 8'd0;
      err_r   <= 1'b0;
      max_r   <= sldc_pkg::MAX_PAYLOAD_RESET;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_data;
      end
      if (go) begin
        phase_r <= phase_nxt;
        cls_r   <= cls_nxt;
        id_r    <= id_nxt;
        len_r   <= len_nxt;
        cnt_r   <= cnt_nxt;
        sf_r    <= sf_nxt;
        ss_r    <= ss_nxt;
        ck_r    <= ck_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sync_length_checksum_deframer_core.sv -----
`default_nettype none

// Channel   Direction  Ports                          Content
// in        slave      in_tvalid in_tready in_tdata   one received byte
// out       master     out_tvalid out_tready          frame events and payload bytes
//                      out_tdata out_tuser
// cfg       slave      cfg_valid cfg_ready cfg_data   max_payload register
//
// One byte is taken per cycle while the result register is free or being taken;
// a result passes the input register, then the parser and the result register.
// Reset clears the parser state and loads max_payload with 4088.
// While out_tready is low the result register holds; the input register
// still takes one byte, then in_tready drops until the result is taken.

module sync_length_checksum_deframer_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,    // [7:0] byte_in
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,   // [7:0] msg_class, [15:8] msg_id,
                                   // [31:16] payload_length, [47:32] payload_index,
                                   // [55:48] data_byte, [56] error_seen, rest zero
  output logic [1:0]  out_tuser,   // [1:0] event_res
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data     // [15:0] max_payload
);

  logic           in_v_r;
  logic [7:0]     in_byte_r;
  logic           out_v_r;
  sldc_pkg::res_t out_res_r;
  logic           slot_free;
  logic           go;
  logic           res_valid;
  sldc_pkg::res_t res;

  assign slot_free = !out_v_r || out_tready;
  assign go        = in_v_r && slot_free;
  assign in_tready = !in_v_r || slot_free;
  assign cfg_ready = 1'b1;

  sldc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .go        (go),
    .byte_in   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (slot_free) begin
        out_v_r <= go && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (slot_free) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.ev;
  assign out_tdata  = sldc_pkg::out_data_t'{
    pad:            7'd0,
    error_seen:     out_res_r.error_seen,
    data_byte:      out_res_r.data_byte,
    payload_index:  out_res_r.payload_index,
    payload_length: out_res_r.payload_length,
    msg_id:         out_res_r.msg_id,
    msg_class:      out_res_r.msg_class
  };

endmodule

`default_nettype wire

// ----- hdl/sldc_checker.sv -----
`default_nettype none

module sldc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [63:0] out_tdata,
  input wire [1:0]  out_tuser
);

  sldc_pkg::out_data_t od;
  logic                err_seen_r;

  assign od = sldc_pkg::out_data_t'(out_tdata);

  // Remembers that an accepted result already carried the error flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_tvalid && out_tready && od.error_seen) begin
      err_seen_r <= 1'b1;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result request changed while stalled");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err_seen_r |-> od.error_seen)
    else $error("error flag cleared after a checksum failure");

  a_bad_sets_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == sldc_pkg::EV_BAD |-> od.error_seen)
    else $error("bad checksum event without error flag");

  a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != sldc_pkg::EV_DATA |->
      od.payload_index == 16'd0 && od.data_byte == 8'd0)
    else $error("frame event carries payload index or data");

endmodule

bind sync_length_checksum_deframer_core sldc_checker u_sldc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- tb/sync_length_checksum_deframer_core_tb.sv -----
`timescale 1ns / 1ps

module sync_length_checksum_deframer_core_tb;

  typedef enum logic [3:0] {
    HUNT_B1, HUNT_B2, GET_CLASS, GET_ID, GET_LEN_LO, GET_LEN_HI,
    GET_PAYLOAD, GET_CK_A, GET_CK_B
  } rx_phase_t;

  typedef enum int {FRAME_OK, FRAME_BAD_CK, FRAME_CUT} flaw_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'd0;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [15:0] cfg_data   = 16'd0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [63:0] out_tdata;
  wire  [1:0]  out_tuser;
  wire         cfg_ready;

  sync_length_checksum_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] byte_in
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] class, [15:8] id, [31:16] length,
                               // [47:32] index, [55:48] data, [56] error_seen
    .out_tuser  (out_tuser),   // [1:0] event_res
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // [15:0] max_payload
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // Parser state as the design should hold it.
  rx_phase_t   rx_phase        = HUNT_B1;
  logic [7:0]  frame_class     = 8'd0;
  logic [7:0]  frame_id        = 8'd0;
  logic [15:0] hdr_len         = 16'd0;
  logic [15:0] payload_seen    = 16'd0;
  logic [7:0]  fl_sum_a        = 8'd0;
  logic [7:0]  fl_sum_b        = 8'd0;
  logic [7:0]  ck_a_rcvd       = 8'd0;
  logic        sticky_err      = 1'b0;
  logic [15:0] max_payload_now = sldc_pkg::MAX_PAYLOAD_RESET;

  sldc_pkg::res_t expected_events[$];
  int   errors = 0;
  int   frame_bytes = 0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;

  function automatic void fletcher_add(input logic [7:0] b);
    fl_sum_a = fl_sum_a + b;
    fl_sum_b = fl_sum_b + fl_sum_a;
  endfunction

  // One parser step; returns 1 when the byte raises an event.
  function automatic bit parser_advance(input logic [7:0] b, output sldc_pkg::event_t ev);
    ev = sldc_pkg::EV_DATA;
    parser_advance = 1'b0;
    case (rx_phase)
      HUNT_B2: begin
        if (b == sldc_pkg::SYNC_SECOND) rx_phase = GET_CLASS;
        else if (b != sldc_pkg::SYNC_FIRST) rx_phase = HUNT_B1;
      end
      GET_CLASS: begin
        frame_class = b;
        fl_sum_a = 8'd0;
        fl_sum_b = 8'd0;
        fletcher_add(b);
        rx_phase = GET_ID;
      end
      GET_ID: begin
        frame_id = b;
        fletcher_add(b);
        rx_phase = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        hdr_len = {8'd0, b};
        fletcher_add(b);
        rx_phase = GET_LEN_HI;
      end
      GET_LEN_HI: begin
        hdr_len = {b, hdr_len[7:0]};
        fletcher_add(b);
        payload_seen = 16'd0;
        if (hdr_len > max_payload_now) begin
          rx_phase = HUNT_B1;
          ev = sldc_pkg::EV_OVERSIZE;
          parser_advance = 1'b1;
        end else begin
          rx_phase = (hdr_len == 16'd0) ? GET_CK_A : GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        fletcher_add(b);
        ev = sldc_pkg::EV_DATA;
        parser_advance = 1'b1;
      end
      GET_CK_A: begin
        ck_a_rcvd = b;
        rx_phase = GET_CK_B;
      end
      GET_CK_B: begin
        rx_phase = HUNT_B1;
        if (ck_a_rcvd == fl_sum_a && b == fl_sum_b) begin
          ev = sldc_pkg::EV_GOOD;
        end else begin
          sticky_err = 1'b1;
          ev = sldc_pkg::EV_BAD;
        end
        parser_advance = 1'b1;
      end
      default: begin
        rx_phase = (b == sldc_pkg::SYNC_FIRST) ? HUNT_B2 : HUNT_B1;
      end
    endcase
  endfunction

  task automatic track_byte(input logic [7:0] b);
    sldc_pkg::res_t   r;
    sldc_pkg::event_t ev;
    sldc_pkg::event_t dummy;
    logic [15:0] idx;
    logic [7:0]  c, i, lo, hi;
    idx = (rx_phase == GET_PAYLOAD) ? payload_seen : 16'd0;
    if (parser_advance(b, ev)) begin
      r.data_byte = 8'd0;
      if (ev == sldc_pkg::EV_DATA) begin
        r.data_byte = b;
        payload_seen = payload_seen + 16'd1;
        if (payload_seen >= hdr_len) rx_phase = GET_CK_A;
      end else begin
        idx = 16'd0;
      end
      r.ev             = ev;
      r.msg_class      = frame_class;
      r.msg_id         = frame_id;
      r.payload_length = hdr_len;
      r.payload_index  = idx;
      r.error_seen     = sticky_err;
      expected_events.push_back(r);
      if (ev == sldc_pkg::EV_OVERSIZE) begin
        // The held header bytes are searched again for a sync pair.
        c  = frame_class;
        i  = frame_id;
        lo = hdr_len[7:0];
        hi = hdr_len[15:8];
        rx_phase = HUNT_B1;
        void'(parser_advance(c, dummy));
        void'(parser_advance(i, dummy));
        void'(parser_advance(lo, dummy));
        void'(parser_advance(hi, dummy));
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    sldc_pkg::res_t      want;
    sldc_pkg::out_data_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_events.size() == 0) begin
        $error("event_res: expected no result, got %0d", out_tuser);
        errors++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_res", want.ev, out_tuser);
        check_field("msg_class", want.msg_class, got.msg_class);
        check_field("msg_id", want.msg_id, got.msg_id);
        check_field("payload_length", want.payload_length, got.payload_length);
        check_field("payload_index", want.payload_index, got.payload_index);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("error_seen", want.error_seen, got.error_seen);
        check_field("tdata_pad", 16'd0, got.pad);
      end
    end
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic set_idling(input int mode);
    case (mode)
      1: begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
      3: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
      default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    track_byte(b);
  endtask

  // Stop sending and let the pipeline empty; bytes that raise no event may
  // still be in flight, so the extra cycles that the caller asks for follow.
  task automatic drain(input int extra);
    in_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [15:0] v);
    drain(4);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_payload_now = v;
  endtask

  // Oversize frames stop after the header; the rest carry payload and check bytes, unless cut short.
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input flaw_t flaw);
    logic [7:0] frame[$];
    logic [7:0] sa, sb;
    int         k;
    int         cut;
    frame.push_back(sldc_pkg::SYNC_FIRST);
    frame.push_back(sldc_pkg::SYNC_SECOND);
    frame.push_back(cls);
    frame.push_back(id);
    frame.push_back(len[7:0]);
    frame.push_back(len[15:8]);
    if (len <= max_payload_now) begin
      for (k = 0; k < len; k++) frame.push_back(8'($urandom_range(255)));
      sa = 8'd0;
      sb = 8'd0;
      for (k = 2; k < frame.size(); k++) begin
        sa = sa + frame[k];
        sb = sb + sa;
      end
      frame.push_back(sa);
      frame.push_back(sb);
      if (flaw == FRAME_BAD_CK) begin
        k = frame.size() - 1 - $urandom_range(1);
        frame[k] = frame[k] ^ 8'($urandom_range(255, 1));
      end else if (flaw == FRAME_CUT) begin
        cut = $urandom_range(frame.size() - 1, (max_payload_now <= 64) ? 2 : 6);
        while (frame.size() > cut) void'(frame.pop_back());
      end
    end
    frame_bytes += frame.size();
    foreach (frame[n]) send_byte(frame[n]);
  endtask

  task automatic test_sync_hunt;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sldc_pkg::SYNC_FIRST);   // repeated first sync byte before the real pair
    send_frame(8'hFF, 8'h00, 16'd0, FRAME_OK);
  endtask

  task automatic test_bad_checksum;
    send_frame(8'h01, 8'h80, 16'd2, FRAME_BAD_CK);
  endtask

  task automatic test_oversize_rescan;
    // The held class and id form a sync pair that the rescan must find.
    send_frame(sldc_pkg::SYNC_FIRST, sldc_pkg::SYNC_SECOND, 16'hFFFF, FRAME_OK);
  endtask

  task automatic test_random_frames(input logic [15:0] limit, input int mode,
                                    input int budget);
    int          lim;
    int          start;
    int          pick;
    logic [7:0]  cls, id;
    logic [15:0] len;
    flaw_t       flaw;
    lim = limit;
    write_max_payload(limit);
    set_idling(mode);
    start = frame_bytes;
    while (frame_bytes - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_byte(8'($urandom_range(255)));
      end else if (pick < 12) begin
        send_byte(sldc_pkg::SYNC_FIRST);
      end else begin
        cls = ($urandom_range(9) == 0) ? sldc_pkg::SYNC_FIRST : 8'($urandom_range(255));
        id  = ($urandom_range(9) == 0) ? sldc_pkg::SYNC_SECOND : 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 20 && lim != 65535) begin
          len = 16'($urandom_range(65535, lim + 1));
          case ($urandom_range(3))
            0: begin cls = sldc_pkg::SYNC_FIRST; id = sldc_pkg::SYNC_SECOND; end
            1: begin id = sldc_pkg::SYNC_FIRST; len[7:0] = sldc_pkg::SYNC_SECOND; end
            2: len[15:8] = sldc_pkg::SYNC_FIRST;
            default: ;
          endcase
        end else if (pick < 30) begin
          len = 16'($urandom_range((lim < 64) ? lim : 64));
        end else begin
          len = 16'($urandom_range((lim < 12) ? lim : 12));
        end
        pick = $urandom_range(99);
        flaw = (pick < 75) ? FRAME_OK : (pick < 90) ? FRAME_BAD_CK : FRAME_CUT;
        send_frame(cls, id, len, flaw);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0);
    test_sync_hunt;
    test_bad_checksum;
    test_oversize_rescan;

    test_random_frames(16'hFFFF, 0, 105);
    test_random_frames(16'd0,    1, 105);
    test_random_frames(16'd12,   2, 105);
    test_random_frames(16'd4088, 3, 105);
    test_random_frames(16'd3,    2, 105);
    test_random_frames(16'd40,   1, 105);

    drain(10);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sldc_pkg.sv
hdl/sldc_parser.sv
hdl/sync_length_checksum_deframer_core.sv
hdl/sldc_checker.sv
tb/sync_length_checksum_deframer_core_tb.sv
